FILE: rtl/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// shared constants and helpers for the modbus rtu frame checker
// ----------------------------------------------------------------------------
package mbrtu_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned REASON_W  = 3;
    localparam int unsigned POS_W     = 3;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;

    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;

    localparam logic [POS_W-1:0]  POS_ADDR     = 3'd0;
    localparam logic [POS_W-1:0]  POS_FUNC     = 3'd1;
    localparam logic [POS_W-1:0]  POS_REG_HI   = 3'd2;
    localparam logic [POS_W-1:0]  POS_REG_LO   = 3'd3;
    localparam logic [POS_W-1:0]  POS_CRC_HI   = 3'd6;
    localparam logic [POS_W-1:0]  POS_LAST     = 3'd7;

    localparam logic [BYTE_W-1:0] DEV_ADDR_RST = 8'd1;

    localparam logic [BYTE_W-1:0] FUNC_A = 8'd1;
    localparam logic [BYTE_W-1:0] FUNC_B = 8'd2;
    localparam logic [BYTE_W-1:0] FUNC_C = 8'd80;
    localparam logic [BYTE_W-1:0] FUNC_D = 8'd81;
    localparam logic [BYTE_W-1:0] FUNC_E = 8'd82;

    localparam logic [REASON_W-1:0] REASON_OK       = 3'd0;
    localparam logic [REASON_W-1:0] REASON_ADDR     = 3'd1;
    localparam logic [REASON_W-1:0] REASON_REG      = 3'd2;
    localparam logic [REASON_W-1:0] REASON_CRC      = 3'd3;
    localparam logic [REASON_W-1:0] REASON_FUNC     = 3'd4;

    // one byte of the reflected crc, unrolled over eight bit steps
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic known_function(input logic [BYTE_W-1:0] f);
        return (f == FUNC_A) || (f == FUNC_B) || (f == FUNC_C) ||
               (f == FUNC_D) || (f == FUNC_E);
    endfunction

endpackage

FILE: rtl/mbrtu_if.sv
// ----------------------------------------------------------------------------
// mbrtu channel interfaces
// received byte channel and frame result channel
// ----------------------------------------------------------------------------
interface mbrtu_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mbrtu_res_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [7:0] command;
    logic [2:0] reject_reason;

    modport source (output valid, output accepted, output command,
                    output reject_reason, input ready);
    modport sink   (input valid, input accepted, input command,
                    input reject_reason, output ready);
endinterface

FILE: rtl/modbus_rtu_frame_checker.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker
// groups received bytes into 8-byte modbus rtu frames, runs the crc-16 and
// reports one check result per frame
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  i_rx      in   valid/ready     rx_byte[7:0]
//  o_res     out  valid/ready     accepted, command[7:0], reject_reason[2:0]
//  apb       in   psel/penable    device_address at byte addresses 0-3
//
//  one byte per cycle unless a held result stalls; a byte waits in the input
//  register while the crc/field update runs, and the result is registered
//  from the eighth byte of a frame; the single-byte crc update bounds the clock
//  reset puts the frame position to the first byte, crc to ffff, address 1
//  a held result stalls the input once the last byte of the next frame
//  reaches the input register
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mbrtu_rx_if.sink                       i_rx,
    mbrtu_res_if.source                    o_res,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mbrtu_pkg::PADDR_W-1:0]  paddr,
    input  logic [mbrtu_pkg::PDATA_W-1:0]  pwdata,
    output logic [mbrtu_pkg::PDATA_W-1:0]  prdata,
    output logic                           pready
);
    import mbrtu_pkg::*;

    logic [BYTE_W-1:0]   r_dev_addr;

    logic                r_in_vld;
    logic [BYTE_W-1:0]   r_in_byte;

    logic [POS_W-1:0]    r_pos,       n_pos;
    logic [CRC_W-1:0]    r_crc,       n_crc;
    logic [BYTE_W-1:0]   r_faddr,     n_faddr;
    logic [BYTE_W-1:0]   r_ffunc,     n_ffunc;
    logic                r_reg_nz,    n_reg_nz;
    logic [BYTE_W-1:0]   r_crc_hi,    n_crc_hi;

    logic                r_out_vld;
    logic                r_out_acc,   n_out_acc;
    logic [BYTE_W-1:0]   r_out_cmd;
    logic [REASON_W-1:0] r_out_reason, n_out_reason;

    logic                s1_last;
    logic                s1_go;
    logic                in_take;
    logic                cfg_wr;
    logic [CRC_W-1:0]    rx_crc;
    logic                byte_nz;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[PADDR_W-1];
    assign prdata = paddr[PADDR_W-1] ? '0
                                     : {{(PDATA_W-BYTE_W){1'b0}}, r_dev_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RST;
        end else if (cfg_wr) begin
            r_dev_addr <= pwdata[BYTE_W-1:0];
        end
    end

    // handshake
    assign s1_last   = (r_pos == POS_LAST);
    assign s1_go     = r_in_vld && (!s1_last || !r_out_vld || o_res.ready);
    assign i_rx.ready = !r_in_vld || s1_go;
    assign in_take   = i_rx.valid && i_rx.ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (s1_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // frame update
    assign byte_nz = (r_in_byte != '0);
    assign rx_crc  = {r_crc_hi, r_in_byte};

    always_comb begin
        n_pos    = r_pos + POS_W'(1);
        n_crc    = r_crc;
        n_faddr  = r_faddr;
        n_ffunc  = r_ffunc;
        n_reg_nz = r_reg_nz;
        n_crc_hi = r_crc_hi;
        if (r_pos < POS_CRC_HI) begin
            n_crc = crc_byte(r_crc, r_in_byte);
        end
        unique case (r_pos)
            POS_ADDR:   n_faddr  = r_in_byte;
            POS_FUNC:   n_ffunc  = r_in_byte;
            POS_REG_HI: n_reg_nz = byte_nz;
            POS_REG_LO: n_reg_nz = r_reg_nz | byte_nz;
            POS_CRC_HI: n_crc_hi = r_in_byte;
            POS_LAST: begin
                n_pos = POS_ADDR;
                n_crc = CRC_INIT;
            end
            default: ;
        endcase
    end

    always_comb begin
        priority if (r_faddr != r_dev_addr) begin
            n_out_reason = REASON_ADDR;
        end else if (r_reg_nz) begin
            n_out_reason = REASON_REG;
        end else if (rx_crc != r_crc) begin
            n_out_reason = REASON_CRC;
        end else if (!known_function(r_ffunc)) begin
            n_out_reason = REASON_FUNC;
        end else begin
            n_out_reason = REASON_OK;
        end
        n_out_acc = (n_out_reason == REASON_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_ADDR;
            r_crc    <= CRC_INIT;
            r_faddr  <= '0;
            r_ffunc  <= '0;
            r_reg_nz <= 1'b0;
            r_crc_hi <= '0;
        end else if (s1_go) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_faddr  <= n_faddr;
            r_ffunc  <= n_ffunc;
            r_reg_nz <= n_reg_nz;
            r_crc_hi <= n_crc_hi;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go && s1_last) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_last) begin
            r_out_acc    <= n_out_acc;
            r_out_cmd    <= r_ffunc;
            r_out_reason <= n_out_reason;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.accepted      = r_out_acc;
    assign o_res.command       = r_out_cmd;
    assign o_res.reject_reason = r_out_reason;

    // checks
    a_acc_matches_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_acc == (r_out_reason == REASON_OK)))
        else $error("accepted flag disagrees with reject reason");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_last) |=> (r_pos == POS_ADDR && r_crc == CRC_INIT))
        else $error("frame state not restarted after last byte");

    a_crc_init_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_ADDR) |-> (r_crc == CRC_INIT))
        else $error("crc not at initial value at frame start");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_res.ready) |-> !(s1_go && s1_last))
        else $error("pending result overwritten");

endmodule
